// ===== src/bfipe_pkg.sv =====
`timescale 1ns / 1ps

package bfipe_pkg;

   localparam int IMAGE_BYTES    = 128;
   localparam int MAX_FIELD_BITS = 64;
   localparam int BYTE_ADDR_W    = $clog2(IMAGE_BYTES);
   localparam int CNT_W          = $clog2(MAX_FIELD_BITS);

   typedef enum logic [2:0] {
      OP_CLEAR   = 3'd0,
      OP_WRITE   = 3'd1,
      OP_READ    = 3'd2,
      OP_INSERT  = 3'd3,
      OP_EXTRACT = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TOO_LARGE = 2'd1,
      STATUS_TOO_WIDE  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_BYTE_WAIT,
      ST_BIT_READ,
      ST_BIT_MODIFY,
      ST_DONE
   } state_type;

   function automatic logic [7:0] flip_byte(input logic [7:0] x);
      logic [7:0] y;
      y = ((x & 8'hF0) >> 4) | ((x & 8'h0F) << 4);
      y = ((y & 8'hCC) >> 2) | ((y & 8'h33) << 2);
      y = ((y & 8'hAA) >> 1) | ((y & 8'h55) << 1);
      return y;
   endfunction

endpackage

// ===== src/bfipe_ram.sv =====
`timescale 1ns / 1ps

module bfipe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/bit_field_image_pack_extract_core.sv =====
`timescale 1ns / 1ps

// This core keeps a 1024-bit image in a byte-wide RAM and serves one request at a time.
// A request is taken when req_valid is high and req_stall is low; req_stall stays high
// from the cycle after acceptance until the core is idle again.
// One result is given for every request on the rsp_ channel, held until rsp_stall is low.
// Clear, byte write and unknown operations go from the check state straight to the done state.
// A byte read passes through the byte wait state between check and done.
// Insert and extract run a read state and a modify state for each field bit, then go to done.
// Per bit, the single RAM port pair reads the byte, and an insert of a 1 bit writes it back.
// A field that is too wide, or an insert value that does not fit, ends after the check cycle.
// A clear resets all per-byte valid flags together; bytes never written read as zero.
// The csr_ write sets the classic bit-numbering mode and must only come while the core is idle.
// Reset empties the image, clears the mode and drops any pending result.
// While the receiver stalls, the result is held and one more request may be accepted
// and worked on; it then waits in its final state until the output register is free.

module bit_field_image_pack_extract_core
   import bfipe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [6:0]  req_byte_addr,
   input  logic [7:0]  req_byte_in,
   input  logic [9:0]  req_field_begin,
   input  logic [9:0]  req_field_end,
   input  logic [63:0] req_field_value,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_byte_out,
   output logic [63:0] rsp_extracted_value,
   output logic [1:0]  rsp_status,

   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   state_type               state_ff, state_in;
   op_type                  op_ff, op_in;
   logic [6:0]              idx_ff, idx_in;
   logic [7:0]              bin_ff, bin_in;
   logic [9:0]              begin_ff, begin_in;
   logic [9:0]              end_ff, end_in;
   logic [63:0]             val_ff, val_in;
   logic [9:0]              pos_ff, pos_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [CNT_W-1:0]        last_ff, last_in;
   logic                    reversed_ff, reversed_in;
   logic [7:0]              byte_res_ff, byte_res_in;
   logic [63:0]             xval_ff, xval_in;
   status_type              status_ff, status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              rsp_byte_ff, rsp_byte_in;
   logic [63:0]             rsp_xval_ff, rsp_xval_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic                    classic_ff, classic_in;
   logic [IMAGE_BYTES-1:0]  valid_ff, valid_in;
   logic                    rd_valid_ff, rd_valid_in;

   logic [9:0]              lo;
   logic [9:0]              hi;
   logic [9:0]              diff;
   logic [6:0]              width7;
   logic                    too_wide;
   logic                    too_large;
   logic                    idx_in_image;
   logic                    pos_in_image;
   logic [BYTE_ADDR_W-1:0]  idx_addr;
   logic [BYTE_ADDR_W-1:0]  pos_addr;
   logic [BYTE_ADDR_W-1:0]  rd_addr;
   logic [7:0]              rd_data;
   logic [7:0]              cur_byte;
   logic [2:0]              bit_sel;
   logic                    out_free;
   logic                    ram_wr_en;
   logic [BYTE_ADDR_W-1:0]  ram_wr_addr;
   logic [7:0]              ram_wr_data;

   assign lo           = (begin_ff < end_ff) ? begin_ff : end_ff;
   assign hi           = (begin_ff < end_ff) ? end_ff : begin_ff;
   assign diff         = hi - lo;
   assign width7       = {1'b0, diff[5:0]} + 7'd1;
   assign too_wide     = diff >= 10'(MAX_FIELD_BITS);
   assign too_large    = (val_ff >> width7) != 64'd0;
   assign idx_in_image = 32'(idx_ff) < IMAGE_BYTES;
   assign pos_in_image = 32'(pos_ff[9:3]) < IMAGE_BYTES;
   assign idx_addr     = BYTE_ADDR_W'(idx_ff);
   assign pos_addr     = BYTE_ADDR_W'(pos_ff[9:3]);
   assign rd_addr      = (op_ff == OP_READ) ? idx_addr : pos_addr;
   assign cur_byte     = rd_valid_ff ? rd_data : 8'd0;
   assign bit_sel      = 3'd7 - pos_ff[2:0];
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rd_valid_in  = valid_ff[rd_addr];

   bfipe_ram #(
      .WIDTH (8),
      .DEPTH (IMAGE_BYTES)
   ) u_image (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      bin_in        = bin_ff;
      begin_in      = begin_ff;
      end_in        = end_ff;
      val_in        = val_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      last_in       = last_ff;
      reversed_in   = reversed_ff;
      byte_res_in   = byte_res_ff;
      xval_in       = xval_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_byte_in   = rsp_byte_ff;
      rsp_xval_in   = rsp_xval_ff;
      rsp_status_in = rsp_status_ff;
      classic_in    = csr_wr_en ? csr_wr_data : classic_ff;
      valid_in      = valid_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = pos_addr;
      ram_wr_data   = cur_byte;
      req_stall     = state_ff != ST_IDLE;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = op_type'(req_operation);
               idx_in   = req_byte_addr;
               bin_in   = req_byte_in;
               begin_in = req_field_begin;
               end_in   = req_field_end;
               val_in   = req_field_value;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            reversed_in = begin_ff > end_ff;
            pos_in      = (begin_ff > end_ff) ? lo : hi;
            cnt_in      = '0;
            last_in     = CNT_W'(diff);
            byte_res_in = 8'd0;
            xval_in     = 64'd0;
            status_in   = STATUS_OK;
            state_in    = ST_DONE;
            case (op_ff)
               OP_CLEAR: begin
                  valid_in = '0;
               end
               OP_WRITE: begin
                  if (idx_in_image) begin
                     ram_wr_en          = 1'b1;
                     ram_wr_addr        = idx_addr;
                     ram_wr_data        = classic_ff ? flip_byte(bin_ff) : bin_ff;
                     valid_in[idx_addr] = 1'b1;
                  end
               end
               OP_READ: begin
                  state_in = ST_BYTE_WAIT;
               end
               OP_INSERT: begin
                  if (too_wide) begin
                     status_in = STATUS_TOO_WIDE;
                  end else if (too_large) begin
                     status_in = STATUS_TOO_LARGE;
                  end else begin
                     state_in = ST_BIT_READ;
                  end
               end
               OP_EXTRACT: begin
                  if (too_wide) begin
                     status_in = STATUS_TOO_WIDE;
                  end else begin
                     state_in = ST_BIT_READ;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_BYTE_WAIT: begin
            if (idx_in_image) begin
               byte_res_in = classic_ff ? flip_byte(cur_byte) : cur_byte;
            end
            state_in = ST_DONE;
         end
         ST_BIT_READ: begin
            state_in = ST_BIT_MODIFY;
         end
         ST_BIT_MODIFY: begin
            if (op_ff == OP_INSERT) begin
               if (val_ff[cnt_ff] && pos_in_image) begin
                  ram_wr_en          = 1'b1;
                  ram_wr_data        = cur_byte | (8'd1 << bit_sel);
                  valid_in[pos_addr] = 1'b1;
               end
            end else begin
               xval_in[cnt_ff] = pos_in_image && cur_byte[bit_sel];
            end
            if (cnt_ff == last_ff) begin
               state_in = ST_DONE;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               pos_in   = reversed_ff ? pos_ff + 10'd1 : pos_ff - 10'd1;
               state_in = ST_BIT_READ;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = byte_res_ff;
               rsp_xval_in   = xval_ff;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         classic_ff   <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         classic_ff   <= classic_in;
         valid_ff     <= valid_in;
      end
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      bin_ff        <= bin_in;
      begin_ff      <= begin_in;
      end_ff        <= end_in;
      val_ff        <= val_in;
      pos_ff        <= pos_in;
      cnt_ff        <= cnt_in;
      last_ff       <= last_in;
      reversed_ff   <= reversed_in;
      byte_res_ff   <= byte_res_in;
      xval_ff       <= xval_in;
      status_ff     <= status_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_xval_ff   <= rsp_xval_in;
      rsp_status_ff <= rsp_status_in;
      rd_valid_ff   <= rd_valid_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_byte_out        = rsp_byte_ff;
   assign rsp_extracted_value = rsp_xval_ff;
   assign rsp_status          = rsp_status_ff;

   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_CHECK)
      else $error("Accepted request did not enter the check state.");

   a_modify_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BIT_MODIFY |-> $past(state_ff) == ST_BIT_READ)
      else $error("Bit update without a preceding RAM read.");

   a_bit_loop_ok: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BIT_READ || state_ff == ST_BIT_MODIFY |->
         status_ff == STATUS_OK && (op_ff == OP_INSERT || op_ff == OP_EXTRACT))
      else $error("Bit loop running for a rejected or non-field request.");

   a_error_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STATUS_OK |->
         rsp_xval_ff == 64'd0 && rsp_byte_ff == 8'd0)
      else $error("Rejected request returned data.");

   a_one_data_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_byte_ff != 8'd0 |-> rsp_xval_ff == 64'd0)
      else $error("Byte read and field value both nonzero.");

endmodule
